>>> rtl/core/mnop_pkg.sv
// Package for the MIDI note pairing core: table sizes, request codes and
// the entry and control types shared by the cell row and the top level.
// No dependencies.
package mnop_pkg;

    localparam int MAX_OPEN  = 64;
    localparam int TICK_BITS = 32;
    localparam int NOTE_BITS = 7;
    localparam int CHAN_BITS = 4;

    localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
    localparam logic [1:0] REQ_NOTE_OFF = 2'd1;

    typedef logic [TICK_BITS-1:0] t_tick;

    typedef struct packed {
        logic [NOTE_BITS-1:0] note;
        logic [CHAN_BITS-1:0] chan;
        t_tick                tick;
    } t_entry;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic                 push;  // shift toward the old end, new entry at cell 0
        logic                 pull;  // close the gap at the first hit
        logic                 cmp;   // latch the per-cell match against key
        logic [NOTE_BITS-1:0] note;
        logic [CHAN_BITS-1:0] chan;
    } t_cell_ctrl;

endpackage

>>> rtl/core/mnop_cell.sv
// One cell of the open-note row: holds one entry, its valid bit and a match
// flag. Depends on mnop_pkg.
module mnop_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mnop_pkg::t_cell_ctrl i_ctrl,
    input  mnop_pkg::t_entry    i_left,
    input  logic                i_left_valid,
    input  mnop_pkg::t_entry    i_right,
    input  logic                i_right_valid,
    input  logic                i_hit,
    output mnop_pkg::t_entry    o_entry,
    output logic                o_valid,
    output logic                o_hit,
    output logic                o_first,
    output mnop_pkg::t_tick     o_sel_tick
);

    mnop_pkg::t_entry r_entry;
    logic             r_valid;
    logic             r_match;

    // A newer hit exists at or before this cell: take the older neighbor.
    assign o_hit      = i_hit | r_match;
    assign o_first    = r_match & ~i_hit;
    assign o_sel_tick = o_first ? r_entry.tick : '0;
    assign o_entry    = r_entry;
    assign o_valid    = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctrl.push) begin
                r_valid <= i_left_valid;
            end else if (i_ctrl.pull && o_hit) begin
                r_valid <= i_right_valid;
            end
            if (i_ctrl.cmp) begin
                r_match <= r_valid && (r_entry.note == i_ctrl.note)
                           && (r_entry.chan == i_ctrl.chan);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_entry <= i_left;
        end else if (i_ctrl.pull && o_hit) begin
            r_entry <= i_right;
        end
    end

endmodule

>>> rtl/core/midi_note_on_off_pairing_core.sv
// MIDI note-on/note-off pairing core: a row of mnop_cell holds open notes.
// A note-off latches the match flags; its result is loaded into the output
// register from the removal step, later while an earlier result is stalled.
// Input: note-on and other events are accepted back to back; a note-off
// has a compare, then a removal step; it waits while a result is stalled.
// Reset: synchronous, clears cell valid bits, overflow flag, FSM and output
// valid; no clearing pass. Depends on mnop_pkg and mnop_cell.
module midi_note_on_off_pairing_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [6:0]  i_note_number,
    input  logic [3:0]  i_channel,
    input  logic [31:0] i_event_tick,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_start_tick,
    output logic [31:0] o_end_tick,
    output logic [6:0]  o_note_number_res,
    output logic        o_overflow_seen
);

    localparam int N  = mnop_pkg::MAX_OPEN;
    localparam int TB = mnop_pkg::TICK_BITS;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FIND = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic                  r_overflow;
    mnop_pkg::t_tick       r_off_tick;

    logic                  r_out_valid;
    logic [31:0]           r_start_tick;
    logic [31:0]           r_end_tick;
    logic [6:0]            r_note_res;
    logic                  r_ovf_res;

    mnop_pkg::t_cell_ctrl  w_ctrl;
    mnop_pkg::t_entry      w_new;
    mnop_pkg::t_entry      w_entry  [N];
    mnop_pkg::t_entry      w_left   [N];
    mnop_pkg::t_entry      w_right  [N];
    mnop_pkg::t_tick       w_sel    [N];
    logic [N-1:0]          w_valid;
    logic [N-1:0]          w_left_v;
    logic [N-1:0]          w_right_v;
    logic [N-1:0]          w_hit_in;
    logic [N-1:0]          w_hit;
    logic [N-1:0]          w_first;
    mnop_pkg::t_tick       w_start;

    logic w_accept;
    logic w_full;
    logic w_found;
    logic w_out_free;
    logic w_emit;

    // Input side: take a transaction only in idle; a note-off holds the input
    // for its removal step, and longer while a stalled result fills the
    // output register.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_full     = w_valid[N-1];
    assign w_found    = w_hit[N-1];
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = (r_state == S_FIND) && w_out_free && w_found
                        && (r_off_tick > w_start);

    assign w_new.note = i_note_number;
    assign w_new.chan = i_channel;
    assign w_new.tick = TB'(i_event_tick);

    // Broadcast controls: push a note-on at cell 0, latch matches on a
    // note-off, close the gap once the removal step may proceed.
    always_comb begin
        w_ctrl.push = w_accept && (i_req_type == mnop_pkg::REQ_NOTE_ON) && !w_full;
        w_ctrl.cmp  = w_accept && (i_req_type == mnop_pkg::REQ_NOTE_OFF);
        w_ctrl.pull = (r_state == S_FIND) && w_out_free && w_found;
        w_ctrl.note = i_note_number;
        w_ctrl.chan = i_channel;
    end

    // Cell row: cell 0 holds the newest entry. Newest match = first hit.
    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g]   = w_new;
            assign w_left_v[g] = 1'b1;
            assign w_hit_in[g] = 1'b0;
        end else begin : g_body
            assign w_left[g]   = w_entry[g-1];
            assign w_left_v[g] = w_valid[g-1];
            assign w_hit_in[g] = w_hit[g-1];
        end
        if (g == N-1) begin : g_tail
            assign w_right[g]   = w_entry[g];
            assign w_right_v[g] = 1'b0;
        end else begin : g_mid
            assign w_right[g]   = w_entry[g+1];
            assign w_right_v[g] = w_valid[g+1];
        end

        mnop_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_left       (w_left[g]),
            .i_left_valid (w_left_v[g]),
            .i_right      (w_right[g]),
            .i_right_valid(w_right_v[g]),
            .i_hit        (w_hit_in[g]),
            .o_entry      (w_entry[g]),
            .o_valid      (w_valid[g]),
            .o_hit        (w_hit[g]),
            .o_first      (w_first[g]),
            .o_sel_tick   (w_sel[g])
        );
    end

    // Only the first hit drives its tick; OR the row together.
    always_comb begin
        w_start = '0;
        for (int i = 0; i < N; i++) begin
            w_start = w_start | w_sel[i];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_ctrl.cmp) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                // Hold until the output slot can take a result.
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && (i_req_type == mnop_pkg::REQ_NOTE_ON) && w_full) begin
                r_overflow <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Note number of the hit entry equals the note-off key; take it from the
    // row so the latched key need not be held.
    function automatic logic [6:0] hit_note();
        logic [6:0] v;
        v = '0;
        for (int i = 0; i < N; i++) begin
            v = v | (w_first[i] ? 7'(w_entry[i].note) : 7'd0);
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_ctrl.cmp) begin
            r_off_tick <= w_new.tick;
        end
        if (w_emit) begin
            r_start_tick <= 32'(w_start);
            r_end_tick   <= 32'(r_off_tick);
            r_note_res   <= hit_note();
            r_ovf_res    <= r_overflow;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_start_tick      = r_start_tick;
    assign o_end_tick        = r_end_tick;
    assign o_note_number_res = r_note_res;
    assign o_overflow_seen   = r_ovf_res;

    // Occupied cells always form an unbroken run from cell 0.
    a_valid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, w_valid} + (N+1)'(1)))
        else $error("open-note row has a gap");

    // At most one cell is the newest match.
    a_first_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one first hit");

    // A result is only loaded from the removal step.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIND))
        else $error("result raised outside removal step");

    // Overflow flag is sticky.
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |=> r_overflow)
        else $error("overflow flag cleared");

endmodule
